@@ rtl/core/dsfr_pkg.sv @@
package dsfr_pkg;

    // Frame layout
    localparam int FRAME_LEN = 16;
    localparam int POS_W     = 4;
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_COUNT_MSB = POS_W'(3);
    localparam logic [POS_W-1:0] POS_COUNT_LSB = POS_W'(6);

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int SCALE_W = 16;
    localparam int CONC_W  = 39;
    localparam int PROD_W  = COUNT_W + SCALE_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3528;

    // count*scale/1000 = ((count*scale) >> 3) / 125
    // q / 125 = (q * RECIP) >> 52, exact for q < 2^50
    localparam int QUO_W    = PROD_W - 3;
    localparam int HALF_W   = 23;
    localparam int RECIP_SH = 52;
    localparam int ACC_W    = 91;
    localparam logic [45:0] RECIP    = 46'd36028797018964;
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP[45:HALF_W];

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               checksum_ok;
        logic [COUNT_W-1:0] particle_count;
    } t_frame;

endpackage

@@ rtl/core/dsfr_front.sv @@
module dsfr_front
    import dsfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_frame            o_q_data
);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [BYTE_W-1:0]  r_sum,   n_sum;
    logic [COUNT_W-1:0] r_shift, n_shift;
    logic               last;
    logic               accept;
    logic [BYTE_W-1:0]  chk;

    assign last    = (r_pos >= POS_LAST);
    assign o_ready = !last || !i_q_full;
    assign accept  = i_valid && o_ready;
    assign chk     = r_sum + i_rx_byte;

    assign o_q_push                = accept && last;
    assign o_q_data.checksum_ok    = (chk == '0);
    assign o_q_data.particle_count = r_shift;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_shift = r_shift;
        if (accept) begin
            if (last) begin
                n_pos   = '0;
                n_sum   = '0;
                n_shift = '0;
            end else begin
                n_pos = r_pos + 1'b1;
                n_sum = chk;
                if (r_pos >= POS_COUNT_MSB && r_pos <= POS_COUNT_LSB) begin
                    n_shift = {r_shift[COUNT_W-BYTE_W-1:0], i_rx_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_shift <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_shift <= n_shift;
        end
    end

endmodule

@@ rtl/core/dsfr_fifo.sv @@
module dsfr_fifo
    import dsfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_frame o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_frame          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/dsfr_back.sv @@
module dsfr_back
    import dsfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SCALE_W-1:0] i_scale_factor,
    input  logic               i_q_empty,
    input  t_frame             i_q_data,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_checksum_ok,
    output logic [COUNT_W-1:0] o_particle_count,
    output logic [CONC_W-1:0]  o_concentration_centi
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PP0  = 3'd1;  // lo*lo
    localparam logic [2:0] ST_PP1  = 3'd2;  // lo*hi
    localparam logic [2:0] ST_PP2  = 3'd3;  // hi*lo
    localparam logic [2:0] ST_PP3  = 3'd4;  // hi*hi
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]          r_state, n_state;
    t_frame              r_job;
    logic [PROD_W-1:0]   r_prod;
    logic [2*HALF_W-1:0] r_pp;
    logic [ACC_W-1:0]    r_acc;
    logic                r_out_valid;
    logic                r_out_ok;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic [CONC_W-1:0]   r_out_conc;

    logic [QUO_W-1:0]    quo;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [ACC_W-1:0]    acc_add;
    logic [ACC_W-1:0]    acc_sum;
    logic                out_free;
    logic                fin_load;

    assign quo      = r_prod[PROD_W-1:3];
    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign fin_load = (r_state == ST_FIN) && out_free;

    // Operand select for the shared partial-product multiplier
    always_comb begin
        if (r_state == ST_PP0 || r_state == ST_PP1) begin
            mul_a = quo[HALF_W-1:0];
        end else begin
            mul_a = {1'b0, quo[QUO_W-1:HALF_W]};
        end
        if (r_state == ST_PP0 || r_state == ST_PP2) begin
            mul_b = RECIP_LO;
        end else begin
            mul_b = RECIP_HI;
        end
    end

    // Weight of the partial product registered in the previous step
    always_comb begin
        unique case (r_state)
            ST_PP1:         acc_add = {{(ACC_W-2*HALF_W){1'b0}}, r_pp};
            ST_PP2, ST_PP3: acc_add = {{(ACC_W-3*HALF_W){1'b0}}, r_pp, {HALF_W{1'b0}}};
            ST_FIN:         acc_add = {r_pp[ACC_W-2*HALF_W-1:0], {(2*HALF_W){1'b0}}};
            default:        acc_add = '0;
        endcase
    end

    assign acc_sum = r_acc + acc_add;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_PP0;
            ST_PP0:  n_state = ST_PP1;
            ST_PP1:  n_state = ST_PP2;
            ST_PP2:  n_state = ST_PP3;
            ST_PP3:  n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job  <= i_q_data;
            r_prod <= i_q_data.particle_count * i_scale_factor;
        end
        r_pp <= mul_a * mul_b;
        if (r_state == ST_PP0) begin
            r_acc <= '0;
        end else if (r_state != ST_FIN && r_state != ST_IDLE) begin
            r_acc <= acc_sum;
        end
        if (fin_load) begin
            r_out_ok   <= r_job.checksum_ok;
            r_out_cnt  <= r_job.particle_count;
            r_out_conc <= acc_sum[ACC_W-1:RECIP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid               = r_out_valid;
    assign o_checksum_ok         = r_out_ok;
    assign o_particle_count      = r_out_cnt;
    assign o_concentration_centi = r_out_conc;

endmodule

@@ rtl/core/dust_sensor_frame_receiver.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// byte in  | i_valid / o_ready  | i_rx_byte
// result   | o_valid / i_ready  | o_checksum_ok, o_particle_count,
//          |                    | o_concentration_centi
// config   | i_cfg_we (no wait) | i_cfg_wdata -> scale factor
//
// One byte request accepted per cycle while o_ready is high; frames are cut by
// position only. Each result passes the back-end states PP0, PP1, PP2, PP3 and FIN
// (one 32x16 product at the pop, then four 23x23 partial products on one shared
// multiplier and a final add); o_valid rises when FIN finds the output free.
// o_ready drops only on a frame's last byte while the frame queue is full.
// Synchronous active-low reset clears framing state, queue and output valid;
// the scale factor returns to 3528 and any partial frame is dropped.
module dust_sensor_frame_receiver
    import dsfr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_checksum_ok,
    output logic [COUNT_W-1:0] o_particle_count,
    output logic [CONC_W-1:0]  o_concentration_centi,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    // Scale factor; the user must write it only while the block is idle, which the block does not enforce
    logic [SCALE_W-1:0] r_scale_factor;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    t_frame q_wdata;
    t_frame q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_factor <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale_factor <= i_cfg_wdata;
        end
    end

    // Front end: framing, running sum and count capture
    dsfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // Completed frames wait here so the byte stream waits on the arithmetic only when the queue is full
    dsfr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Back end: concentration = floor(count * scale / 1000), output register
    dsfr_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_scale_factor        (r_scale_factor),
        .i_q_empty             (q_empty),
        .i_q_data              (q_rdata),
        .o_q_pop               (q_pop),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_checksum_ok         (o_checksum_ok),
        .o_particle_count      (o_particle_count),
        .o_concentration_centi (o_concentration_centi)
    );

endmodule

@@ verif/tb_dust_sensor_frame_receiver.sv @@
`default_nettype none

module tb_dust_sensor_frame_receiver
    import dsfr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int CENTI_DIV    = 1000;     // count*scale/1000 gives hundredths
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_BYTES  = 48;
    localparam int SETTLE_CYCLES = 16;      // settle margin for the back end
    localparam int REPORT_LIMIT = 10;

    typedef enum {CK_GOOD, CK_BAD, CK_RANDOM} t_ck_kind;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill_kind;

    typedef struct packed {
        logic               checksum_ok;
        logic [COUNT_W-1:0] particle_count;
        logic [CONC_W-1:0]  concentration_centi;
    } t_frame_result;

    // Frame predictor plus the queue of frame results still owed by the block.
    class frame_scoreboard;
        t_frame_result      owed_q[$];
        logic [POS_W-1:0]   frame_pos;
        logic [BYTE_W-1:0]  byte_sum;
        logic [COUNT_W-1:0] count_sr;
        logic [SCALE_W-1:0] scale;
        int                 mismatches;

        function new();
            frame_pos  = '0;
            byte_sum   = '0;
            count_sr   = '0;
            scale      = SCALE_RESET;
            mismatches = 0;
        endfunction

        function void set_scale(logic [SCALE_W-1:0] value);
            scale = value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Called for every accepted byte request.
        function void note_byte(logic [BYTE_W-1:0] b);
            t_frame_result r;
            logic [BYTE_W-1:0] neg_sum;
            logic [63:0] prod;
            if (frame_pos >= POS_LAST) begin
                neg_sum = -byte_sum;
                prod    = 64'(count_sr) * 64'(scale);
                r.checksum_ok         = (b == neg_sum);
                r.particle_count      = count_sr;
                r.concentration_centi = CONC_W'(prod / CENTI_DIV);
                owed_q.push_back(r);
                frame_pos = '0;
                byte_sum  = '0;
                count_sr  = '0;
            end else begin
                byte_sum = byte_sum + b;
                if (frame_pos >= POS_COUNT_MSB && frame_pos <= POS_COUNT_LSB)
                    count_sr = {count_sr[COUNT_W-BYTE_W-1:0], b};
                frame_pos = frame_pos + 1'b1;
            end
        endfunction

        function void check_result(logic ok, logic [COUNT_W-1:0] cnt,
                                   logic [CONC_W-1:0] conc);
            t_frame_result want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with none owed: ok=%0b count=%0d conc=%0d",
                             $realtime, ok, cnt, conc);
                return;
            end
            want = owed_q.pop_front();
            if (want.checksum_ok !== ok || want.particle_count !== cnt ||
                want.concentration_centi !== conc) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: mismatch: expected ok=%0b count=%0d conc=%0d, ",
                              "got ok=%0b count=%0d conc=%0d"}, $realtime,
                             want.checksum_ok, want.particle_count,
                             want.concentration_centi, ok, cnt, conc);
            end
        endfunction
    endclass

    // Every block input is known from time zero.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [BYTE_W-1:0]  i_rx_byte   = '0;
    logic               i_ready     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [SCALE_W-1:0] i_cfg_wdata = '0;

    logic               o_ready;
    logic               o_valid;
    logic               o_checksum_ok;
    logic [COUNT_W-1:0] o_particle_count;
    logic [CONC_W-1:0]  o_concentration_centi;

    frame_scoreboard sb;
    int stream_pos = 0;     // position of the next sent byte within its frame
    int burst_left = 0;     // byte requests left before the sender takes a gap

    dust_sensor_frame_receiver dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_rx_byte             (i_rx_byte),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_checksum_ok         (o_checksum_ok),
        .o_particle_count      (o_particle_count),
        .o_concentration_centi (o_concentration_centi),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side: compare every accepted result against the oldest one owed.
    // Sampled in the active region of the rising edge, so pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_checksum_ok, o_particle_count, o_concentration_centi);
    end

    // Receiver back-pressure: a mode picked at random whenever the current one runs out,
    // ranging from always ready through coin flips and a fixed duty pattern to
    // mostly stalled.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned stall_tick = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 200);
        end else begin
            mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (stall_tick % 4 != 0);
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One byte request. Entered at a falling edge, returns at a falling edge;
    // valid stays up inside a burst and drops for a random gap between bursts.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
        stream_pos = (stream_pos + 1) % FRAME_LEN;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Sixteen bytes laid out as a sensor frame; the count goes big-endian into
    // the count bytes and the trailer is chosen by ck.
    task automatic send_frame(input logic [COUNT_W-1:0] count, input t_ck_kind ck,
                              input t_fill_kind fill);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            case (fill)
                FILL_ZERO: b = '0;
                FILL_ONES: b = '1;
                default:   b = BYTE_W'($urandom);
            endcase
            if (i >= POS_COUNT_MSB && i <= POS_COUNT_LSB)
                b = count[BYTE_W*(POS_COUNT_LSB - i) +: BYTE_W];
            sum = sum + b;
            send_byte(b);
        end
        case (ck)
            CK_GOOD: b = -sum;
            CK_BAD:  b = (-sum) ^ BYTE_W'($urandom_range(1, 255));
            default: b = BYTE_W'($urandom);
        endcase
        send_byte(b);
    endtask

    // Sender goes quiet until every owed result is out, then a settle margin
    // for the back end. Returns at a falling edge.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_scale(value);
    endtask

    initial begin
        logic [SCALE_W-1:0] next_scale;
        logic [COUNT_W-1:0] cnt;
        int                 phase_start;
        int                 bytes_sent;

        sb = new();
        bytes_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-ones frame with the largest count and a good trailer,
        // then an all-zero frame with a broken trailer, at the reset scale.
        send_frame('1, CK_GOOD, FILL_ONES);
        send_frame('0, CK_BAD, FILL_ZERO);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1:       next_scale = '1;
                    2:       next_scale = '0;
                    3:       next_scale = 16'd1;
                    5:       next_scale = 16'd1000;
                    default: next_scale = SCALE_W'($urandom);
                endcase
                drain();
                write_scale(next_scale);
                // Largest count against the largest scale: top of the range.
                if (next_scale == '1)
                    send_frame('1, CK_GOOD, FILL_RANDOM);
            end
            phase_start = stream_pos;
            bytes_sent  = 0;
            while (bytes_sent < PHASE_BYTES) begin
                case ($urandom_range(0, 7))
                    0:       cnt = '0;
                    1:       cnt = '1;
                    2:       cnt = $urandom_range(0, 999);
                    default: cnt = $urandom;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        // Mostly realigned; now and then left shifted on purpose.
                        if ($urandom_range(0, 4) != 0) begin
                            while (stream_pos != 0) begin
                                send_byte(BYTE_W'($urandom));
                                bytes_sent++;
                            end
                        end
                        send_frame(cnt, CK_GOOD, FILL_RANDOM);
                        bytes_sent += FRAME_LEN;
                    end
                    7, 8: begin
                        send_frame(cnt, ($urandom_range(0, 1) != 0) ? CK_BAD : CK_RANDOM,
                                   FILL_RANDOM);
                        bytes_sent += FRAME_LEN;
                    end
                    default: begin
                        // Stray bytes: every later frame slips by this many.
                        repeat ($urandom_range(1, 15)) begin
                            send_byte(BYTE_W'($urandom));
                            bytes_sent++;
                        end
                    end
                endcase
            end
            // Finish the frame in flight so the scale only changes between frames.
            while (stream_pos != 0)
                send_byte(BYTE_W'($urandom));
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d results still owed", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
